// ----- src/spmd_pkg.sv -----
// Shared types, constants and helpers for the sync prefix message deframer.
package spmd_pkg;

    localparam int unsigned NUM_KINDS = 6;

    localparam logic [2:0] KIND_TIME    = 3'd0;
    localparam logic [2:0] KIND_NET     = 3'd1;
    localparam logic [2:0] KIND_RTC     = 3'd2;
    localparam logic [2:0] KIND_SENSOR  = 3'd3;
    localparam logic [2:0] KIND_DISPLAY = 3'd4;
    localparam logic [2:0] KIND_USER    = 3'd5;
    localparam logic [2:0] KIND_NONE    = 3'd7;

    localparam logic [7:0] TIME_LEN    = 8'd11;
    localparam logic [7:0] NET_LEN     = 8'd11;
    localparam logic [7:0] RTC_LEN     = 8'd7;
    localparam logic [7:0] SENSOR_LEN  = 8'd11;
    localparam logic [7:0] DISPLAY_LEN = 8'd7;
    localparam logic [7:0] USER_LEN    = 8'd4;

    localparam logic [7:0] BODY_START = 8'd3;

    localparam logic [1:0] REASON_NONE  = 2'd0;
    localparam logic [1:0] REASON_FULL  = 2'd1;
    localparam logic [1:0] REASON_LIMIT = 2'd2;
    localparam logic [1:0] REASON_CUT   = 2'd3;

    localparam logic [2:0] REG_SYNC_PREFIX   = 3'd0;
    localparam logic [2:0] REG_CODE_TIME     = 3'd1;
    localparam logic [2:0] REG_CODE_NET      = 3'd2;
    localparam logic [2:0] REG_CODE_RTC      = 3'd3;
    localparam logic [2:0] REG_CODE_SENSOR   = 3'd4;
    localparam logic [2:0] REG_CODE_DISPLAY  = 3'd5;
    localparam logic [2:0] REG_CODE_USER     = 3'd6;
    localparam logic [2:0] REG_CAPTURE_LIMIT = 3'd7;

    localparam logic [7:0] CAPTURE_LIMIT_RESET = 8'd64;

    typedef logic [2:0] t_kind;

    typedef struct packed {
        logic [15:0]                 sync_prefix;
        logic [NUM_KINDS-1:0][7:0]   code;
        logic [7:0]                  capture_limit;
    } t_cfg;

    typedef struct packed {
        logic  hit;
        t_kind kind;
    } t_hit;

    function automatic logic [7:0] kind_len(input t_kind kind);
        logic [7:0] len;
        case (kind)
            KIND_TIME:    len = TIME_LEN;
            KIND_NET:     len = NET_LEN;
            KIND_RTC:     len = RTC_LEN;
            KIND_SENSOR:  len = SENSOR_LEN;
            KIND_DISPLAY: len = DISPLAY_LEN;
            KIND_USER:    len = USER_LEN;
            default:      len = USER_LEN;
        endcase
        return len;
    endfunction

endpackage

// ----- src/spmd_if.sv -----
// Channel interfaces: received bytes, message body beats and register writes.
interface spmd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface spmd_msg_if;
    logic       valid;
    logic       ready;
    logic [2:0] msg_kind;
    logic [7:0] byte_offset;
    logic [7:0] body_byte;
    logic       last;
    logic [1:0] end_reason;
    modport source (output valid, output msg_kind, output byte_offset, output body_byte,
                    output last, output end_reason, input ready);
    modport sink (input valid, input msg_kind, input byte_offset, input body_byte,
                  input last, input end_reason, output ready);
endinterface

interface spmd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/spmd_cfg.sv -----
// Configuration register file: sync prefix, six type codes and capture limit.
module spmd_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [2:0]    i_wr_index,
    input  logic [15:0]   i_wr_data,
    output spmd_pkg::t_cfg o_cfg
);

    spmd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_prefix   <= 16'd0;
            r_cfg.code[0]       <= 8'd1;
            r_cfg.code[1]       <= 8'd2;
            r_cfg.code[2]       <= 8'd3;
            r_cfg.code[3]       <= 8'd4;
            r_cfg.code[4]       <= 8'd5;
            r_cfg.code[5]       <= 8'd6;
            r_cfg.capture_limit <= spmd_pkg::CAPTURE_LIMIT_RESET;
        end else if (i_wr_en) begin
            case (i_wr_index)
                spmd_pkg::REG_SYNC_PREFIX:   r_cfg.sync_prefix   <= i_wr_data;
                spmd_pkg::REG_CODE_TIME:     r_cfg.code[0]       <= i_wr_data[7:0];
                spmd_pkg::REG_CODE_NET:      r_cfg.code[1]       <= i_wr_data[7:0];
                spmd_pkg::REG_CODE_RTC:      r_cfg.code[2]       <= i_wr_data[7:0];
                spmd_pkg::REG_CODE_SENSOR:   r_cfg.code[3]       <= i_wr_data[7:0];
                spmd_pkg::REG_CODE_DISPLAY:  r_cfg.code[4]       <= i_wr_data[7:0];
                spmd_pkg::REG_CODE_USER:     r_cfg.code[5]       <= i_wr_data[7:0];
                spmd_pkg::REG_CAPTURE_LIMIT: r_cfg.capture_limit <= i_wr_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/spmd_match.sv -----
// Header matcher: prefix compare and first-wins priority over the type codes.
module spmd_match (
    input  spmd_pkg::t_cfg i_cfg,
    input  logic [15:0]    i_window,
    input  logic [7:0]     i_rx_byte,
    output spmd_pkg::t_hit o_hit
);

    logic prefix_ok;

    assign prefix_ok = (i_window == i_cfg.sync_prefix);

    always_comb begin
        o_hit.hit  = 1'b0;
        o_hit.kind = spmd_pkg::KIND_NONE;
        for (int k = spmd_pkg::NUM_KINDS - 1; k >= 0; k--) begin
            if (prefix_ok && (i_rx_byte == i_cfg.code[k])) begin
                o_hit.hit  = 1'b1;
                o_hit.kind = 3'(k);
            end
        end
    end

endmodule

// ----- src/spmd_core.sv -----
// Message tracker: window, offset and length counters, and the result register.
module spmd_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  spmd_pkg::t_cfg i_cfg,
    input  spmd_pkg::t_hit i_hit,
    input  logic           i_accept,
    input  logic [7:0]     i_rx_byte,
    input  logic           i_out_ready,
    output logic [15:0]    o_window,
    output logic           o_out_valid,
    output logic [2:0]     o_msg_kind,
    output logic [7:0]     o_byte_offset,
    output logic [7:0]     o_body_byte,
    output logic           o_last,
    output logic [1:0]     o_end_reason
);

    logic [15:0]       r_window;
    spmd_pkg::t_kind   r_kind, n_kind;
    logic [7:0]        r_offset, n_offset;
    logic [7:0]        r_remaining, n_remaining;
    logic              r_out_valid;
    logic [2:0]        r_msg_kind;
    logic [7:0]        r_byte_offset;
    logic [7:0]        r_body_byte;
    logic              r_last;
    logic [1:0]        r_end_reason;

    logic              active;
    logic [7:0]        inc_offset;
    logic [7:0]        dec_remaining;
    logic [1:0]        reason;
    logic [1:0]        out_reason;

    assign active        = (r_kind != spmd_pkg::KIND_NONE);
    assign inc_offset    = r_offset + 8'd1;
    assign dec_remaining = r_remaining - 8'd1;

    always_comb begin
        reason = spmd_pkg::REASON_NONE;
        if (dec_remaining == 8'd0) begin
            reason = spmd_pkg::REASON_FULL;
        end else if (({1'b0, inc_offset} + 9'd1) >= {1'b0, i_cfg.capture_limit}) begin
            reason = spmd_pkg::REASON_LIMIT;
        end

        out_reason = reason;
        if (i_hit.hit && (reason == spmd_pkg::REASON_NONE)) begin
            out_reason = spmd_pkg::REASON_CUT;
        end

        n_kind      = r_kind;
        n_offset    = r_offset;
        n_remaining = r_remaining;
        if (i_hit.hit) begin
            n_kind      = i_hit.kind;
            n_offset    = spmd_pkg::BODY_START;
            n_remaining = spmd_pkg::kind_len(i_hit.kind) - spmd_pkg::BODY_START;
        end else if (active) begin
            n_offset    = inc_offset;
            n_remaining = dec_remaining;
            if (reason != spmd_pkg::REASON_NONE) begin
                n_kind = spmd_pkg::KIND_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= 16'd0;
            r_kind      <= spmd_pkg::KIND_NONE;
            r_offset    <= 8'd0;
            r_remaining <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_window    <= {r_window[7:0], i_rx_byte};
                r_kind      <= n_kind;
                r_offset    <= n_offset;
                r_remaining <= n_remaining;
                r_out_valid <= active;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // load the result beat
    always_ff @(posedge i_clk) begin
        if (i_accept && active) begin
            r_msg_kind    <= r_kind;
            r_byte_offset <= r_offset;
            r_body_byte   <= i_rx_byte;
            r_last        <= (out_reason != spmd_pkg::REASON_NONE);
            r_end_reason  <= out_reason;
        end
    end

    assign o_window      = r_window;
    assign o_out_valid   = r_out_valid;
    assign o_msg_kind    = r_msg_kind;
    assign o_byte_offset = r_byte_offset;
    assign o_body_byte   = r_body_byte;
    assign o_last        = r_last;
    assign o_end_reason  = r_end_reason;

endmodule

// ----- src/sync_prefix_message_deframer.sv -----
// Sync prefix message deframer top level.
// A body byte appears on the output in the cycle after its input beat is accepted.
// Throughput: one byte per cycle while the output is not stalled; outside reset
// the input is ready whenever the result register is empty or being drained in the same cycle.
// Reset (synchronous, active low) restores register defaults, clears the
// window and counters, and drops any message in progress.
module sync_prefix_message_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spmd_byte_if.sink   i_rx,
    spmd_cfg_if.sink    i_cfg,
    spmd_msg_if.source  o_msg
);

    spmd_pkg::t_cfg cfg;
    spmd_pkg::t_hit hit;
    logic [15:0]    window;
    logic           accept;
    logic           out_valid;

    assign i_cfg.ready = i_rst_n;
    assign i_rx.ready  = i_rst_n && (!out_valid || o_msg.ready);
    assign accept      = i_rx.valid && i_rx.ready;

    spmd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    spmd_match u_match (
        .i_cfg     (cfg),
        .i_window  (window),
        .i_rx_byte (i_rx.rx_byte),
        .o_hit     (hit)
    );

    spmd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_hit         (hit),
        .i_accept      (accept),
        .i_rx_byte     (i_rx.rx_byte),
        .i_out_ready   (o_msg.ready),
        .o_window      (window),
        .o_out_valid   (out_valid),
        .o_msg_kind    (o_msg.msg_kind),
        .o_byte_offset (o_msg.byte_offset),
        .o_body_byte   (o_msg.body_byte),
        .o_last        (o_msg.last),
        .o_end_reason  (o_msg.end_reason)
    );

    assign o_msg.valid = out_valid;

endmodule

// ----- tb/sv/tb_sync_prefix_message_deframer.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the sync prefix message deframer: directed and random traffic.
module tb_sync_prefix_message_deframer;

    typedef struct packed {
        spmd_pkg::t_kind kind;
        logic [7:0]      offs;
        logic [7:0]      data;
        logic            last;
        logic [1:0]      reason;
    } t_body_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    spmd_byte_if rx_ch ();
    spmd_cfg_if  cfg_ch ();
    spmd_msg_if  msg_ch ();

    sync_prefix_message_deframer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .i_cfg   (cfg_ch),
        .o_msg   (msg_ch)
    );

    logic [7:0]  frame_len [spmd_pkg::NUM_KINDS] = '{spmd_pkg::TIME_LEN, spmd_pkg::NET_LEN,
                                                     spmd_pkg::RTC_LEN, spmd_pkg::SENSOR_LEN,
                                                     spmd_pkg::DISPLAY_LEN, spmd_pkg::USER_LEN};

    spmd_pkg::t_cfg  model_cfg;
    logic [15:0]     model_window;
    spmd_pkg::t_kind model_kind;
    logic [7:0]      model_offs;
    logic [7:0]      model_left;
    t_body_beat      expected_beats [$];

    int error_count = 0;
    int send_gap_pct = 0;
    int sink_stall_pct = 0;
    int hold_cycles = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void reset_model();
        model_cfg.sync_prefix = 16'h0000;
        for (int k = 0; k < spmd_pkg::NUM_KINDS; k++) begin
            model_cfg.code[k] = 8'(k + 1);
        end
        model_cfg.capture_limit = spmd_pkg::CAPTURE_LIMIT_RESET;
        model_window = '0;
        model_kind = spmd_pkg::KIND_NONE;
        model_offs = '0;
        model_left = '0;
    endfunction

    function automatic void apply_reg_write(input logic [2:0] idx, input logic [15:0] value);
        case (idx)
            spmd_pkg::REG_SYNC_PREFIX:   model_cfg.sync_prefix = value;
            spmd_pkg::REG_CAPTURE_LIMIT: model_cfg.capture_limit = value[7:0];
            default: model_cfg.code[idx - spmd_pkg::REG_CODE_TIME] = value[7:0];
        endcase
    endfunction

    function automatic void deframe_byte(input logic [7:0] rx);
        logic [23:0]     three;
        t_body_beat      beat;
        logic            emitted;
        spmd_pkg::t_kind hit;
        three = {model_window, rx};
        model_window = three[15:0];
        emitted = 1'b0;
        beat = '0;
        hit = spmd_pkg::KIND_NONE;
        if (model_kind != spmd_pkg::KIND_NONE) begin
            beat.kind = model_kind;
            beat.offs = model_offs;
            beat.data = rx;
            beat.reason = spmd_pkg::REASON_NONE;
            model_offs = model_offs + 8'd1;
            model_left = model_left - 8'd1;
            if (model_left == 8'd0) begin
                beat.reason = spmd_pkg::REASON_FULL;
            end else if ({1'b0, model_offs} + 9'd1 >= {1'b0, model_cfg.capture_limit}) begin
                beat.reason = spmd_pkg::REASON_LIMIT;
            end
            if (beat.reason != spmd_pkg::REASON_NONE) begin
                model_kind = spmd_pkg::KIND_NONE;
            end
            beat.last = (beat.reason != spmd_pkg::REASON_NONE);
            emitted = 1'b1;
        end
        // scan from the back so the lowest kind wins
        for (int k = spmd_pkg::NUM_KINDS - 1; k >= 0; k--) begin
            if (three == {model_cfg.sync_prefix, model_cfg.code[k]}) begin
                hit = spmd_pkg::t_kind'(k);
            end
        end
        if (hit != spmd_pkg::KIND_NONE) begin
            if (model_kind != spmd_pkg::KIND_NONE) begin
                beat.last = 1'b1;
                beat.reason = spmd_pkg::REASON_CUT;
            end
            model_kind = hit;
            model_offs = spmd_pkg::BODY_START;
            model_left = frame_len[hit] - spmd_pkg::BODY_START;
        end
        if (emitted) begin
            expected_beats.push_back(beat);
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_beats
        t_body_beat want;
        if (i_rst_n) begin
            if (msg_ch.valid && msg_ch.ready) begin
                if (expected_beats.size() == 0) begin
                    $error("body beat with none expected: kind %0d, offset %0d, byte %0h",
                           msg_ch.msg_kind, msg_ch.byte_offset, msg_ch.body_byte);
                    error_count++;
                end else begin
                    want = expected_beats.pop_front();
                    check_field("msg_kind", 16'(want.kind), 16'(msg_ch.msg_kind));
                    check_field("byte_offset", 16'(want.offs), 16'(msg_ch.byte_offset));
                    check_field("body_byte", 16'(want.data), 16'(msg_ch.body_byte));
                    check_field("last", 16'(want.last), 16'(msg_ch.last));
                    check_field("end_reason", 16'(want.reason), 16'(msg_ch.end_reason));
                end
            end
            if (rx_ch.valid && rx_ch.ready) begin
                deframe_byte(rx_ch.rx_byte);
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                apply_reg_write(cfg_ch.index, cfg_ch.data);
            end
        end
    end

    initial begin
        msg_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                msg_ch.ready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else begin
                msg_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] value);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            rx_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= value;
        @(posedge i_clk);
        while (!rx_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_header(input spmd_pkg::t_kind kind);
        send_byte(model_cfg.sync_prefix[15:8]);
        send_byte(model_cfg.sync_prefix[7:0]);
        send_byte(model_cfg.code[kind]);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        rx_ch.valid <= 1'b0;
        while (expected_beats.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_regs(input spmd_pkg::t_cfg setting);
        write_reg(spmd_pkg::REG_SYNC_PREFIX, setting.sync_prefix);
        for (int k = 0; k < spmd_pkg::NUM_KINDS; k++) begin
            write_reg(3'(spmd_pkg::REG_CODE_TIME + k), {8'($urandom), setting.code[k]});
        end
        write_reg(spmd_pkg::REG_CAPTURE_LIMIT, {8'h00, setting.capture_limit});
    endtask

    function automatic spmd_pkg::t_cfg random_setting(input int phase);
        spmd_pkg::t_cfg setting;
        setting.sync_prefix = 16'($urandom);
        for (int k = 0; k < spmd_pkg::NUM_KINDS; k++) begin
            setting.code[k] = 8'($urandom);
        end
        if ($urandom_range(1) == 1) begin
            setting.code[$urandom_range(spmd_pkg::NUM_KINDS - 1)] =
                setting.code[$urandom_range(spmd_pkg::NUM_KINDS - 1)];
        end
        if ($urandom_range(1) == 1) begin
            setting.capture_limit = 8'($urandom_range(12, 5));
        end else begin
            setting.capture_limit = 8'($urandom_range(255, 13));
        end
        if (phase == 0) begin
            setting.sync_prefix = 16'hFFFF;
            setting.capture_limit = 8'd255;
        end else if (phase == 1) begin
            setting.sync_prefix = 16'h0000;
            setting.capture_limit = 8'd5;
        end
        return setting;
    endfunction

    task automatic stream_messages(input int count);
        int              sent;
        int              pick;
        int              body;
        spmd_pkg::t_kind kind;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                kind = spmd_pkg::t_kind'($urandom_range(spmd_pkg::NUM_KINDS - 1));
                send_header(kind);
                if ($urandom_range(3) == 0) begin
                    body = int'(frame_len[kind] - spmd_pkg::BODY_START);
                end else begin
                    body = $urandom_range(12);
                end
                repeat (body) send_byte(8'($urandom));
                sent += 3 + body;
            end else if (pick < 85) begin
                body = $urandom_range(4, 1);
                repeat (body) send_byte(8'($urandom));
                sent += body;
            end else if (pick < 95) begin
                send_byte(model_cfg.sync_prefix[15:8]);
                if ($urandom_range(1) == 1) begin
                    send_byte(model_cfg.sync_prefix[7:0]);
                    sent++;
                end
                send_byte(8'($urandom));
                sent += 2;
            end else begin
                drain_results();
            end
        end
    endtask

    task automatic test_reset_defaults();
        send_byte(model_cfg.code[spmd_pkg::KIND_USER]);
        send_byte(8'hFF);
        send_header(spmd_pkg::KIND_RTC);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(model_cfg.code[spmd_pkg::KIND_USER]);
        send_byte(8'h80);
        drain_results();
    endtask

    task automatic test_capture_limit();
        write_reg(spmd_pkg::REG_CAPTURE_LIMIT, 16'd5);
        send_header(spmd_pkg::KIND_SENSOR);
        send_byte(8'hC3);
        drain_results();
        // rtc length and this limit end the frame on the same beat
        write_reg(spmd_pkg::REG_CAPTURE_LIMIT, 16'd8);
        send_header(spmd_pkg::KIND_RTC);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h0F);
        send_byte(8'hF0);
        drain_results();
    endtask

    task automatic test_header_priority();
        write_reg(spmd_pkg::REG_SYNC_PREFIX, 16'hFFFF);
        write_reg(spmd_pkg::REG_CODE_TIME, 16'h0000);
        for (int k = spmd_pkg::REG_CODE_NET; k <= spmd_pkg::REG_CODE_USER; k++) begin
            write_reg(3'(k), 16'h00FF);
        end
        repeat (4) send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h7E);
        drain_results();
    endtask

    task automatic test_backpressure();
        @(posedge i_clk);
        hold_cycles = 300;
        repeat (10) begin
            send_header(spmd_pkg::t_kind'($urandom_range(spmd_pkg::NUM_KINDS - 1)));
            repeat ($urandom_range(10, 1)) send_byte(8'($urandom));
        end
        drain_results();
    endtask

    task automatic test_random_phases();
        int gap_pct [4] = '{0, 45, 0, 34};
        int stall_pct [4] = '{0, 0, 45, 34};
        for (int p = 0; p < 4; p++) begin
            drain_results();
            send_gap_pct = gap_pct[p];
            sink_stall_pct = stall_pct[p];
            program_regs(random_setting(p));
            stream_messages(500);
        end
    endtask

    initial begin
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = 8'h00;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = spmd_pkg::REG_SYNC_PREFIX;
        cfg_ch.data = 16'h0000;
        reset_model();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_capture_limit();
        test_header_priority();
        test_backpressure();
        test_random_phases();
        drain_results();
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/spmd_pkg.sv
src/spmd_if.sv
src/spmd_cfg.sv
src/spmd_match.sv
src/spmd_core.sv
src/sync_prefix_message_deframer.sv
tb/sv/tb_sync_prefix_message_deframer.sv
